FILE: hw/rtl/sample_metadata_cache_assert.svh
// Assertion macros shared by the sample metadata cache checkers.
// Depends on nothing; included by the checker file.
`ifndef SAMPLE_METADATA_CACHE_ASSERT_SVH
`define SAMPLE_METADATA_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/smc_pkg.sv
// Shared types, constants and helpers for the sample metadata cache.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package smc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int LIST_MAX      = 8;
    localparam int META_WIDTH    = 64;

    localparam int LIST_FIELDS = 8;
    localparam int LIDX_W      = 3;
    localparam int COUNT_W     = 4;
    localparam int ID_W        = 16;
    localparam int SLOT_W      = 3;
    localparam int META_OUT_W  = 64;
    localparam int ENTRY_W     = $clog2(CACHE_ENTRIES);
    localparam int CNT_W       = ENTRY_W + 1;

    typedef logic [ID_W-1:0]       id_t;
    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [META_WIDTH-1:0] meta_t;
    typedef logic [COUNT_W-1:0]    count_t;

    localparam logic [1:0] CMD_STORE  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_PRUNE  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ID_W-1:0]    tag_id;
        logic [63:0]        meta_word;
        logic [COUNT_W-1:0] list_count;
        logic [ID_W-1:0]    list_id_0;
        logic [ID_W-1:0]    list_id_1;
        logic [ID_W-1:0]    list_id_2;
        logic [ID_W-1:0]    list_id_3;
        logic [ID_W-1:0]    list_id_4;
        logic [ID_W-1:0]    list_id_5;
        logic [ID_W-1:0]    list_id_6;
        logic [ID_W-1:0]    list_id_7;
    } cmd_item_t;

    typedef struct packed {
        logic                  found;
        logic [META_OUT_W-1:0] meta_out;
        logic [SLOT_W-1:0]     slot_index;
        logic [ID_W-1:0]       newest_id;
    } res_item_t;

    // Control from the sequencer to the entry store
    typedef struct packed {
        logic   rd_en;
        entry_t rd_addr;
        logic   wr_en;
        entry_t wr_addr;
        id_t    wr_id;
        meta_t  wr_meta;
        logic   inv_en;
        entry_t inv_addr;
    } store_req_t;

    // Registered read data from the entry store
    typedef struct packed {
        logic  valid;
        id_t   id;
        meta_t meta;
    } store_rsp_t;

    // Low slot bits of an entry number
    function automatic logic [SLOT_W-1:0] to_slot(input entry_t e);
        logic [ENTRY_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, e};
        return ext[SLOT_W-1:0];
    endfunction

    // Zero-extend stored metadata to the result field width
    function automatic logic [META_OUT_W-1:0] widen_meta(input meta_t m);
        logic [META_WIDTH+META_OUT_W-1:0] ext;
        ext = {{META_OUT_W{1'b0}}, m};
        return ext[META_OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/smc_match.sv
// Shared id compare unit: is the key among the first count candidates.
// Depends on smc_pkg.
`default_nettype none

module smc_match
    import smc_pkg::*;
(
    input  id_t    key,
    input  id_t    cand [LIST_FIELDS],
    input  count_t count,
    output logic   hit
);

    // Compare the key against every enabled candidate
    always_comb
    begin
        hit = 1'b0;
        for (int e = 0; e < LIST_FIELDS; e++)
        begin
            if ((COUNT_W'(e) < count) && (cand[e] == key))
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/smc_store.sv
// Entry store: id and metadata memories with one read and one write port,
// plus per-entry valid flops. Depends on smc_pkg.
`default_nettype none

module smc_store
    import smc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output store_rsp_t rsp
);

    id_t   id_mem   [CACHE_ENTRIES];
    meta_t meta_mem [CACHE_ENTRIES];

    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;
    id_t                      rd_id_reg;
    meta_t                    rd_meta_reg;

    // Write and read the entry memories
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            id_mem[req.wr_addr]   <= req.wr_id;
            meta_mem[req.wr_addr] <= req.wr_meta;
        end
        if (req.rd_en)
        begin
            rd_id_reg   <= id_mem[req.rd_addr];
            rd_meta_reg <= meta_mem[req.rd_addr];
        end
    end

    // Set valid on write, drop it on invalidate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.inv_en)
            begin
                valid_reg[req.inv_addr] <= 1'b0;
            end
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.id    = rd_id_reg;
    assign rsp.meta  = rd_meta_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sample_metadata_cache.sv
// Channel   Dir  Payload      Handshake
// cmd       in   cmd_item_t   cmd_valid / cmd_ready
// res       out  res_item_t   res_valid / res_ready
//
// Store and lookup scan every entry before their result; a prune scans, then
// checks the newest id; a truncated prune or an unknown command skips the scan.
// The scan reads one entry per cycle through the store's single read port,
// registered in the store, then compares it in smc_match.
// cmd_ready is high only while idle; a result waiting in the output register
// does not block acceptance, only the final write-back of the next transaction.
// Reset clears valid bits, ring pointer, newest id and all handshake state.
`default_nettype none

module sample_metadata_cache
    import smc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_NEWEST = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    id_t              want_reg, want_next;
    meta_t            meta_reg, meta_next;
    count_t           count_reg, count_next;
    id_t              list_reg [LIST_FIELDS];
    id_t              list_next [LIST_FIELDS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    entry_t           chk_idx_reg, chk_idx_next;
    logic             hit_reg, hit_next;
    entry_t           slot_reg, slot_next;
    meta_t            hit_meta_reg, hit_meta_next;
    id_t              newest_reg, newest_next;
    entry_t           ring_reg, ring_next;
    logic             res_valid_reg, res_valid_next;
    res_item_t        res_reg, res_next;

    store_req_t       sreq;
    store_rsp_t       srsp;

    id_t              mkey;
    id_t              mcand [LIST_FIELDS];
    count_t           mcount;
    logic             mhit;

    logic             accept;
    logic             issue;
    logic             entry_hit;
    logic             prune_ok;
    logic             out_free;
    count_t           cnt_m1;
    entry_t           wr_slot;

    smc_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    smc_match u_match (
        .key   (mkey),
        .cand  (mcand),
        .count (mcount),
        .hit   (mhit)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign out_free  = !res_valid_reg || res_ready;
    assign prune_ok  = (count_reg < COUNT_W'(LIST_MAX));
    assign cnt_m1    = count_reg - COUNT_W'(1);
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(CACHE_ENTRIES));
    assign wr_slot   = hit_reg ? slot_reg : ring_reg;

    // Feed the shared compare unit: prune checks the list, others one id
    always_comb
    begin
        mkey   = (state_reg == ST_NEWEST) ? newest_reg : srsp.id;
        mcount = (op_reg == CMD_PRUNE) ? count_reg : COUNT_W'(1);
        for (int e = 0; e < LIST_FIELDS; e++)
        begin
            mcand[e] = list_reg[e];
        end
        if (op_reg != CMD_PRUNE)
        begin
            mcand[0] = want_reg;
        end
    end

    assign entry_hit = (state_reg == ST_SCAN) && chk_vld_reg && srsp.valid && mhit;

    // Sequencer: scan entries, adjust newest, write back and load result
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        want_next     = want_reg;
        meta_next     = meta_reg;
        count_next    = count_reg;
        list_next     = list_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        hit_meta_next = hit_meta_reg;
        newest_next   = newest_reg;
        ring_next     = ring_reg;
        res_valid_next = res_valid_reg;
        res_next      = res_reg;

        sreq          = '0;
        sreq.rd_addr  = cnt_reg[ENTRY_W-1:0];
        sreq.wr_addr  = wr_slot;
        sreq.wr_id    = want_reg;
        sreq.wr_meta  = meta_reg;
        sreq.inv_addr = chk_idx_reg;

        // Drop the result once taken
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = cmd_data.cmd;
                    want_next    = cmd_data.tag_id;
                    if ((cmd_data.cmd == CMD_LOOKUP) && (cmd_data.tag_id == '0))
                    begin
                        want_next = newest_reg;
                    end
                    meta_next    = cmd_data.meta_word[META_WIDTH-1:0];
                    count_next   = cmd_data.list_count;
                    list_next[0] = cmd_data.list_id_0;
                    list_next[1] = cmd_data.list_id_1;
                    list_next[2] = cmd_data.list_id_2;
                    list_next[3] = cmd_data.list_id_3;
                    list_next[4] = cmd_data.list_id_4;
                    list_next[5] = cmd_data.list_id_5;
                    list_next[6] = cmd_data.list_id_6;
                    list_next[7] = cmd_data.list_id_7;
                    cnt_next     = '0;
                    chk_vld_next = 1'b0;
                    hit_next     = 1'b0;
                    if ((cmd_data.cmd == CMD_STORE) || (cmd_data.cmd == CMD_LOOKUP) ||
                        ((cmd_data.cmd == CMD_PRUNE) &&
                         (cmd_data.list_count < COUNT_W'(LIST_MAX))))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next entry read
                if (issue)
                begin
                    sreq.rd_en   = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[ENTRY_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                // Check the entry read last cycle
                if (op_reg == CMD_PRUNE)
                begin
                    if (chk_vld_reg && srsp.valid && !mhit)
                    begin
                        sreq.inv_en = 1'b1;
                    end
                end
                else if (entry_hit && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    slot_next     = chk_idx_reg;
                    hit_meta_next = srsp.meta;
                end

                if (!issue)
                begin
                    state_next = (op_reg == CMD_PRUNE) ? ST_NEWEST : ST_FINISH;
                end
            end

            ST_NEWEST:
            begin
                // Replace newest when the list no longer holds it
                if (!mhit)
                begin
                    newest_next = (count_reg == '0) ? '0 : list_reg[cnt_m1[LIDX_W-1:0]];
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.found      = 1'b0;
                    res_next.meta_out   = '0;
                    res_next.slot_index = '0;
                    res_next.newest_id  = newest_reg;
                    case (op_reg)
                        CMD_STORE:
                        begin
                            sreq.wr_en          = 1'b1;
                            res_next.found      = hit_reg;
                            res_next.slot_index = to_slot(wr_slot);
                            res_next.newest_id  = want_reg;
                            newest_next         = want_reg;
                            if (!hit_reg)
                            begin
                                ring_next = (ring_reg == ENTRY_W'(CACHE_ENTRIES - 1)) ?
                                            '0 : ring_reg + ENTRY_W'(1);
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            res_next.found = hit_reg;
                            if (hit_reg)
                            begin
                                res_next.meta_out   = widen_meta(hit_meta_reg);
                                res_next.slot_index = to_slot(slot_reg);
                            end
                        end
                        CMD_PRUNE:
                        begin
                            res_next.found = prune_ok;
                        end
                        default:
                        begin
                            res_next.found = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= CMD_STORE;
            cnt_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            newest_reg    <= '0;
            ring_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            chk_vld_reg   <= chk_vld_next;
            hit_reg       <= hit_next;
            newest_reg    <= newest_next;
            ring_reg      <= ring_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        want_reg     <= want_next;
        meta_reg     <= meta_next;
        count_reg    <= count_next;
        list_reg     <= list_next;
        chk_idx_reg  <= chk_idx_next;
        slot_reg     <= slot_next;
        hit_meta_reg <= hit_meta_next;
        res_reg      <= res_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/smc_check.sv
// Port-level checker for the sample metadata cache, bound to the top level.
// Depends on smc_pkg and sample_metadata_cache_assert.svh.
`default_nettype none

`include "sample_metadata_cache_assert.svh"

module smc_check
    import smc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire logic      res_valid,
    input wire logic      res_ready,
    input wire res_item_t res_data
);

    // Hold a stalled result
    `SMC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result changed")

    // Go busy after every accepted transaction
    `SMC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready stayed high after accept")

    // Return zero metadata whenever the result reports no hit
    `SMC_ASSERT_NOW(a_meta_zero_on_miss, clk, rst_n, res_valid && !res_data.found, res_data.meta_out == '0, "metadata on a miss")

endmodule

bind sample_metadata_cache smc_check u_smc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

`default_nettype wire
